// File: rtl/shabs_pkg.sv
`default_nettype none

package shabs_pkg;

  // Build-time defaults
  localparam int unsigned FifoDepthDef = 4;

  // Padding marker placed after the last message byte
  localparam logic [7:0] PadByte = 8'h80;

  // Input transaction: one message byte and an end-of-message flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  // Output transaction: one 64-bit quarter of the digest
  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Word queue entry between front end and compression core
  typedef struct packed {
    logic [31:0] word;
    logic        final_word;  // last word of the last block of a message
  } q_entry_t;

  typedef enum logic {
    FrontTake,
    FrontPad
  } front_state_e;

  typedef enum logic [1:0] {
    CoreRound,
    CoreFold,
    CoreEmit
  } core_state_e;

  // Initial hash values
  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Compression sigma functions
  function automatic logic [31:0] big_sigma0(input logic [31:0] a);
    return {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] e);
    return {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  endfunction

  // Message schedule sigma functions
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] y);
    return {y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10);
  endfunction

endpackage

`default_nettype wire

// File: rtl/shabs_fifo.sv
`default_nettype none

// Small word queue between the front end and the compression core
module shabs_fifo #(
  parameter int unsigned Depth = shabs_pkg::FifoDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire shabs_pkg::q_entry_t entry_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output shabs_pkg::q_entry_t     entry_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  shabs_pkg::q_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and occupancy update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/shabs_front.sv
`default_nettype none

// Front end: packs message bytes into big-endian words and generates padding
module shabs_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire shabs_pkg::in_item_t in_i,
  output logic                     push_o,
  output shabs_pkg::q_entry_t      entry_o,
  input  wire logic                full_i
);

  shabs_pkg::front_state_e state_q, state_d;
  logic [31:0] word_q, word_d;     // partially filled word
  logic [5:0]  fill_q, fill_d;     // bytes held in current block
  logic [60:0] count_q, count_d;   // message length in bytes
  logic        pad80_q, pad80_d;   // pad marker already queued
  logic        len_q, len_d;       // length high word already queued

  logic [1:0]  lane;
  logic [3:0]  word_idx;
  logic [31:0] byte_word;
  logic [31:0] pad_mark;
  logic [31:0] merged;
  logic [63:0] bit_len;
  logic        take;
  logic        pad_go;
  logic        pad_final;

  assign lane      = fill_q[1:0];
  assign word_idx  = fill_q[5:2];
  assign byte_word = {in_i.data_byte, 24'h0} >> {lane, 3'b000};
  assign pad_mark  = {shabs_pkg::PadByte, 24'h0} >> {lane, 3'b000};
  assign merged    = word_q | byte_word;
  assign bit_len   = {count_q, 3'b000};
  assign take      = in_valid_i && in_ready_o;
  assign pad_go    = (state_q == shabs_pkg::FrontPad) && !full_i;
  assign pad_final = pad80_q && len_q && (word_idx == 4'd15);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      shabs_pkg::FrontTake: begin
        if (take && in_i.is_last) begin
          state_d = shabs_pkg::FrontPad;
        end
      end
      shabs_pkg::FrontPad: begin
        if (pad_go && pad_final) begin
          state_d = shabs_pkg::FrontTake;
        end
      end
      default: state_d = shabs_pkg::FrontTake;
    endcase
  end

  // Handshake output
  always_comb begin
    in_ready_o = (state_q == shabs_pkg::FrontTake) && !full_i;
  end

  // Word assembly and padding sequence
  always_comb begin
    word_d  = word_q;
    fill_d  = fill_q;
    count_d = count_q;
    pad80_d = pad80_q;
    len_d   = len_q;
    push_o  = 1'b0;
    entry_o = '{word: merged, final_word: 1'b0};
    if (take && in_i.has_byte) begin
      fill_d  = fill_q + 6'd1;
      count_d = count_q + 61'd1;
      if (lane == 2'd3) begin
        push_o = 1'b1;
        word_d = '0;
      end else begin
        word_d = merged;
      end
    end
    if (pad_go) begin
      push_o  = 1'b1;
      word_d  = '0;
      pad80_d = 1'b1;
      fill_d  = {word_idx + 4'd1, 2'b00};
      priority if (!pad80_q) begin
        entry_o.word = word_q | pad_mark;
      end else if (pad_final) begin
        entry_o = '{word: bit_len[31:0], final_word: 1'b1};
      end else if (word_idx == 4'd14) begin
        entry_o.word = bit_len[63:32];
        len_d        = 1'b1;
      end else begin
        entry_o.word = '0;
      end
      // Message done: start the next one clean
      if (pad_final) begin
        fill_d  = '0;
        count_d = '0;
        pad80_d = 1'b0;
        len_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shabs_pkg::FrontTake;
      word_q  <= '0;
      fill_q  <= '0;
      count_q <= '0;
      pad80_q <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      pad80_q <= pad80_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/shabs_core.sv
`default_nettype none

// Compression core: one round per cycle (rounds 0 to 15 wait for queue words), then the fold into the hash state
module shabs_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire shabs_pkg::q_entry_t q_entry_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output shabs_pkg::out_item_t     out_o
);

  shabs_pkg::core_state_e state_q, state_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [1:0]  idx_q, idx_d;
  logic        final_q, final_d;
  logic [31:0] hash_q [8];
  logic [31:0] hash_d [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];

  logic        load_phase;
  logic        round_go;
  logic        emit_done;
  logic [31:0] sched;
  logic [31:0] wt;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign load_phase = (rnd_q[5:4] == 2'b00);
  assign round_go   = (state_q == shabs_pkg::CoreRound) && (!load_phase || q_valid_i);
  assign emit_done  = (state_q == shabs_pkg::CoreEmit) && out_ready_i && (idx_q == 2'd3);

  // Message schedule and round function
  assign sched = w_q[0] + shabs_pkg::small_sigma0(w_q[1]) + w_q[9]
               + shabs_pkg::small_sigma1(w_q[14]);
  assign wt    = load_phase ? q_entry_i.word : sched;
  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + shabs_pkg::big_sigma1(v_q[4]) + ch
               + shabs_pkg::RoundK[rnd_q] + wt;
  assign t2    = shabs_pkg::big_sigma0(v_q[0]) + maj;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      shabs_pkg::CoreRound: begin
        if (round_go && (rnd_q == 6'd63)) begin
          state_d = shabs_pkg::CoreFold;
        end
      end
      shabs_pkg::CoreFold: begin
        state_d = final_q ? shabs_pkg::CoreEmit : shabs_pkg::CoreRound;
      end
      shabs_pkg::CoreEmit: begin
        if (emit_done) begin
          state_d = shabs_pkg::CoreRound;
        end
      end
      default: state_d = shabs_pkg::CoreRound;
    endcase
  end

  // Outputs
  always_comb begin
    q_pop_o           = (state_q == shabs_pkg::CoreRound) && load_phase && q_valid_i;
    out_valid_o       = (state_q == shabs_pkg::CoreEmit);
    out_o.digest_word = {hash_q[{idx_q, 1'b0}], hash_q[{idx_q, 1'b1}]};
    out_o.word_index  = idx_q;
    out_o.last_word   = (idx_q == 2'd3);
  end

  // Working variables, schedule window and hash state
  always_comb begin
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    final_d = final_q;
    hash_d  = hash_q;
    v_d     = v_q;
    w_d     = w_q;
    if (round_go) begin
      rnd_d = rnd_q + 6'd1;
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = wt;
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
      if (rnd_q == 6'd15) begin
        final_d = q_entry_i.final_word;
      end
    end
    if (state_q == shabs_pkg::CoreFold) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + v_q[i];
        v_d[i]    = hash_q[i] + v_q[i];
      end
    end
    if ((state_q == shabs_pkg::CoreEmit) && out_ready_i) begin
      idx_d = idx_q + 2'd1;
    end
    // Digest delivered: back to the initial values for the next message
    if (emit_done) begin
      final_d = 1'b0;
      hash_d  = shabs_pkg::HashInit;
      v_d     = shabs_pkg::HashInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shabs_pkg::CoreRound;
      rnd_q   <= '0;
      idx_q   <= '0;
      final_q <= 1'b0;
      hash_q  <= shabs_pkg::HashInit;
      v_q     <= shabs_pkg::HashInit;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      final_q <= final_d;
      hash_q  <= hash_d;
      v_q     <= v_d;
    end
  end

  // Schedule window, payload only
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

endmodule

`default_nettype wire

// File: rtl/sha256_byte_stream_hasher_unit.sv
// SHA-256 over a byte stream. Each input transaction carries at most one
// message byte; a transaction with is_last set closes the message, and four
// output transactions follow with the digest, 64 bits each, earliest byte in
// the top bits, word_index 0 first. A front end packs bytes into 32-bit
// words and takes one byte per cycle while the word queue (FifoDepth words)
// has room; the compression core runs 64 rounds on each 64-byte block, one
// per cycle unless a round 0 to 15 waits on the queue, then folds the result
// into the hash state. Rounds 0 to 15 take their words straight from the
// queue, and the front end stalls once the queue is full during rounds 16 to
// 63, so a queue deeper than the default four words lets a long message run
// faster. After a last transaction the input stays stalled while the front
// end queues the padding and length words, one per cycle while the queue has
// room, 3 to 18 words; the core then compresses one or two final blocks and
// presents the digest. Input bytes of the next message are taken again as
// soon as the padding is queued.
`default_nettype none

module sha256_byte_stream_hasher_unit #(
  parameter int unsigned FifoDepth = shabs_pkg::FifoDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire shabs_pkg::in_item_t in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output shabs_pkg::out_item_t     out_o
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  shabs_pkg::q_entry_t q_wr_entry;
  shabs_pkg::q_entry_t q_rd_entry;

  // Byte packing and padding
  shabs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .push_o     (q_push),
    .entry_o    (q_wr_entry),
    .full_i     (q_full)
  );

  // Word queue
  shabs_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_rd_entry)
  );

  // Compression and digest output
  shabs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_rd_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// File: rtl/shabs_checker.sv
`default_nettype none

// Port-level checks on the hasher
module shabs_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire shabs_pkg::in_item_t  in_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire shabs_pkg::out_item_t out_o
);

  // A stalled output transaction stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled output transaction keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_o))
    else $error("output payload changed while stalled");

  // Final flag marks exactly the fourth digest word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.last_word == (out_o.word_index == 2'd3)))
    else $error("last_word does not match word_index");

  // Digest words follow back to back in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_o.last_word |=>
      out_valid_o && (out_o.word_index == 2'($past(out_o.word_index) + 2'd1)))
    else $error("digest word sequence broken");

  // Input is held off while a closed message is padded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.is_last |=> !in_ready_o)
    else $error("input accepted straight after end of message");

endmodule

bind sha256_byte_stream_hasher_unit shabs_checker u_shabs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

`default_nettype wire
